@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file wbss_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define WBSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define WBSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wbss_pkg.sv @@
// ----------------------------------------------------------------------------
// wbss_pkg
// Types, register map and constants of the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int POSITION_BITS_DEF     = 32;

	// Number of pattern slots backed by the pattern and care registers.
	localparam int PATTERN_SLOTS = 16;

	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] BYTE_ALL  = 8'hFF;
	localparam logic [7:0] BYTE_NONE = 8'h00;

	typedef enum logic [1:0] {
		STATUS_MATCH       = 2'd0,
		STATUS_DONE        = 2'd1,
		STATUS_BAD_PATTERN = 2'd2
	} status_e;

	typedef enum logic [2:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3,
		REG_MATCH_OFFSET = 3'd4,
		REG_REGION_BASE  = 3'd5,
		REG_FIND_ALL     = 3'd6
	} reg_idx_e;

	typedef struct packed {
		logic [63:0] pattern_low;
		logic [63:0] pattern_high;
		logic [15:0] care;
		logic [4:0]  length;
		logic [31:0] offset;
		logic [63:0] base;
		logic        find_all;
	} cfg_t;

	typedef struct packed {
		logic        hit;
		logic        good;
		logic [63:0] addr;
	} match_t;

	typedef struct packed {
		status_e     status;
		logic [63:0] addr;
		logic [31:0] count;
		logic        eor;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} fifo_push_t;

endpackage

@@ design/wbss_match_core.sv @@
// ----------------------------------------------------------------------------
// wbss_match_core
// Parallel window compare against the masked pattern and match address add.
// ----------------------------------------------------------------------------
module wbss_match_core
	import wbss_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
	parameter int POSITION_BITS     = POSITION_BITS_DEF,
	localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1),
	localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1
) (
	input  cfg_t                                 cfg,
	input  logic [MAX_PATTERN_BYTES-1:0][7:0]    window,
	input  logic [FILL_W-1:0]                    fill,
	input  logic [POSITION_BITS-1:0]             pos,
	input  logic                                 found,
	output match_t                               res
);

	localparam int SLOTS = (MAX_PATTERN_BYTES > PATTERN_SLOTS) ? MAX_PATTERN_BYTES
	                                                           : PATTERN_SLOTS;
	localparam int PAT_W = SLOTS * 8;

	logic [SLOTS-1:0][7:0]         pat_ext;
	logic [SLOTS-1:0]              care_ext;
	logic [5:0]                    len6;
	logic [MAX_PATTERN_BYTES-1:0]  in_use;
	logic [MAX_PATTERN_BYTES-1:0]  miss;
	logic [POSITION_BITS-1:0]      start;

	// Slots past the register-backed ones read as wildcards.
	assign pat_ext  = PAT_W'({cfg.pattern_high, cfg.pattern_low});
	assign care_ext = SLOTS'(cfg.care);

	always_comb begin
		len6 = {1'b0, cfg.length};
		if (len6 == 6'd0) begin
			len6 = 6'd1;
		end
		if (len6 > 6'(MAX_PATTERN_BYTES)) begin
			len6 = 6'(MAX_PATTERN_BYTES);
		end
	end

	// Pattern byte i lines up with window byte MAX - len + i.
	always_comb begin
		logic [5:0] idx6;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			idx6      = 6'(MAX_PATTERN_BYTES) - len6 + 6'(i);
			in_use[i] = (6'(i) < len6);
			miss[i]   = in_use[i] && care_ext[i] &&
			            (window[idx6[IDX_W-1:0]] != pat_ext[i]);
		end
	end

	assign start = pos - POSITION_BITS'(len6 - 6'd1);

	always_comb begin
		res.good = |(care_ext[MAX_PATTERN_BYTES-1:0] & in_use);
		res.hit  = res.good && (6'(fill) >= len6) && (cfg.find_all || !found) && !(|miss);
		res.addr = cfg.base + 64'(start) + {{32{cfg.offset[31]}}, cfg.offset};
	end

endmodule

@@ design/wbss_result_fifo.sv @@
// ----------------------------------------------------------------------------
// wbss_result_fifo
// Small result queue that takes up to two items per cycle and gives one when head_ready is set.
// ----------------------------------------------------------------------------
module wbss_result_fifo
	import wbss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_push_t push,
	output logic       room2,
	output result_t    head,
	output logic       head_valid,
	input  logic       head_ready
);

	result_t            mem [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];
	assign pop        = head_valid && head_ready;
	assign room2      = (count_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_q + PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

endmodule

@@ design/wildcard_byte_signature_scan_unit.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_unit: windowed byte pattern search with wildcards
// Path: an accepted item waits in the input stage, then its results go to the result queue.
// Throughput: 1 item per cycle while the 4-entry result queue has room for two; the input stage stalls otherwise.
// Reset: arst_n clears window, position, count and registers (length to 1).
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan_unit
	import wbss_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
	parameter int POSITION_BITS     = POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [63:0]       match_address,
	output logic [31:0]       match_count,
	output logic              end_of_run
);

	localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

	logic [63:0] pattern_low_q;
	logic [63:0] pattern_high_q;
	logic [15:0] care_q;
	logic [4:0]  length_q;
	logic [31:0] offset_q;
	logic [63:0] base_q;
	logic        find_all_q;
	cfg_t        cfg;
	reg_idx_e    reg_idx;
	logic        cfg_wr;

	logic [7:0]  data_s1;
	logic        last_s1;
	logic        valid_s1;
	logic        s1_go;

	logic [MAX_PATTERN_BYTES-1:0][7:0] window_q;
	logic [MAX_PATTERN_BYTES-1:0][7:0] window_next;
	logic [FILL_W-1:0]                 fill_q;
	logic [FILL_W-1:0]                 fill_next;
	logic [POSITION_BITS-1:0]          pos_q;
	logic                              found_q;
	logic [31:0]                       seen_q;
	logic [31:0]                       seen_next;

	match_t      match;
	fifo_push_t  push;
	result_t     match_r;
	result_t     end_r;
	result_t     head;
	logic        room2;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_e'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			care_q         <= '0;
			length_q       <= 5'd1;
			offset_q       <= '0;
			base_q         <= '0;
			find_all_q     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PATTERN_LOW:  pattern_low_q  <= pwdata;
				REG_PATTERN_HIGH: pattern_high_q <= pwdata;
				REG_CARE_MASK:    care_q         <= pwdata[15:0];
				REG_PATTERN_LEN:  length_q       <= pwdata[4:0];
				REG_MATCH_OFFSET: offset_q       <= pwdata[31:0];
				REG_REGION_BASE:  base_q         <= pwdata;
				REG_FIND_ALL:     find_all_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN_LOW:  prdata = pattern_low_q;
			REG_PATTERN_HIGH: prdata = pattern_high_q;
			REG_CARE_MASK:    prdata = DATA_W'(care_q);
			REG_PATTERN_LEN:  prdata = DATA_W'(length_q);
			REG_MATCH_OFFSET: prdata = DATA_W'(offset_q);
			REG_REGION_BASE:  prdata = base_q;
			REG_FIND_ALL:     prdata = DATA_W'(find_all_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg = '{
		pattern_low:  pattern_low_q,
		pattern_high: pattern_high_q,
		care:         care_q,
		length:       length_q,
		offset:       offset_q,
		base:         base_q,
		find_all:     find_all_q
	};

	// ---------------- input stage ----------------
	assign s1_go    = valid_s1 && room2;
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// ---------------- compare stage ----------------
	// Shift the staged byte in as the newest window byte.
	always_comb begin
		for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
			window_next[k] = window_q[k + 1];
		end
		window_next[MAX_PATTERN_BYTES-1] = data_s1;
	end

	assign fill_next = (fill_q == FILL_W'(MAX_PATTERN_BYTES)) ? fill_q : fill_q + FILL_W'(1);

	wbss_match_core #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.POSITION_BITS     (POSITION_BITS)
	) u_core (
		.cfg    (cfg),
		.window (window_next),
		.fill   (fill_next),
		.pos    (pos_q),
		.found  (found_q),
		.res    (match)
	);

	// Count saturates at all ones.
	assign seen_next = (match.hit && (seen_q != '1)) ? seen_q + 32'd1 : seen_q;

	always_comb begin
		match_r.status = STATUS_MATCH;
		match_r.addr   = match.addr;
		match_r.count  = seen_next;
		match_r.eor    = !last_s1;

		end_r.status = match.good ? STATUS_DONE : STATUS_BAD_PATTERN;
		end_r.addr   = '0;
		end_r.count  = match.good ? seen_next : '0;
		end_r.eor    = 1'b1;

		push.cnt    = s1_go ? (2'(match.hit) + 2'(last_s1)) : 2'd0;
		push.first  = match.hit ? match_r : end_r;
		push.second = end_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			seen_q   <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				// Region ends: drop back to the reset window and counters.
				window_q <= '0;
				fill_q   <= '0;
				pos_q    <= '0;
				found_q  <= 1'b0;
				seen_q   <= '0;
			end else begin
				window_q <= window_next;
				fill_q   <= fill_next;
				pos_q    <= pos_q + POSITION_BITS'(1);
				found_q  <= found_q || match.hit;
				seen_q   <= seen_next;
			end
		end
	end

	// ---------------- result queue ----------------
	wbss_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room2      (room2),
		.head       (head),
		.head_valid (out_valid),
		.head_ready (out_ready)
	);

	assign status        = head.status;
	assign match_address = head.addr;
	assign match_count   = head.count;
	assign end_of_run    = head.eor;

endmodule

@@ design/wbss_checker.sv @@
// ----------------------------------------------------------------------------
// wbss_checker
// Port-level checks on the scanner's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbss_checker
	import wbss_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [63:0] match_address,
	input logic [31:0] match_count,
	input logic        end_of_run
);

	`WBSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result item dropped while stalled")

	`WBSS_ASSERT_NOW(a_match_count, clk, arst_n, out_valid && status == STATUS_MATCH, match_count != 32'd0, "match item with zero count")

	`WBSS_ASSERT_NOW(a_end_shape, clk, arst_n, out_valid && status != STATUS_MATCH, end_of_run && match_address == 64'd0, "end item not closing the run or address nonzero")

	`WBSS_ASSERT_NOW(a_bad_count, clk, arst_n, out_valid && status == STATUS_BAD_PATTERN, match_count == 32'd0, "bad-pattern item with nonzero count")

endmodule

bind wildcard_byte_signature_scan_unit wbss_checker u_wbss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.match_address (match_address),
	.match_count   (match_count),
	.end_of_run    (end_of_run)
);
